/* hw/rtl/led_scanner_bounce_effect_assert.svh */
// Assertion macros for the LED bounce scanner.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef LED_SCANNER_BOUNCE_EFFECT_ASSERT_SVH
`define LED_SCANNER_BOUNCE_EFFECT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define LSBE_ASSERT_NOW(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("led scanner assertion failed");

// Condition holds in the cycle after the trigger.
`define LSBE_ASSERT_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("led scanner assertion failed");

`endif

/* hw/rtl/ledscan_pkg.sv */
// Shared constants and types of the LED bounce scanner.
// Used by the controller, the datapath and the top level.
package ledscan_pkg;

   localparam int COLUMNS       = 6;
   localparam int POS_FRAC_BITS = 8;

   localparam int POS_ONE = 1 << POS_FRAC_BITS;
   localparam int POS_END = (COLUMNS - 1) * POS_ONE;
   localparam int POS_W   = $clog2(POS_END + 1);
   localparam int COL_W   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
   localparam int SUM_W   = ((POS_W > 8) ? POS_W : 8) + 2;
   localparam int REM_W   = POS_FRAC_BITS + 1;
   localparam int BRI_W   = POS_FRAC_BITS + 9;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_RED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 3'd4;

   typedef struct packed {
      logic             frame;
      logic             issue;
      logic [COL_W-1:0] col;
      logic             last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic early;
      logic adv;
   } dp_status_type;

endpackage

/* hw/rtl/ledscan_ctrl.sv */
// Controller of the LED bounce scanner: accepts timestamps and sequences the column scan.
// Depends on ledscan_pkg for the command and status types.
module ledscan_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ledscan_pkg::dp_status_type stat,
   output ledscan_pkg::ctrl_cmd_type  cmd
);
   import ledscan_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      cmd.frame = 1'b0;
      cmd.issue = 1'b0;
      cmd.col   = col_ff;
      cmd.last  = (col_ff == COL_W'(COLUMNS - 1));
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !stat.early) begin
               cmd.frame = 1'b1;
               col_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.adv) begin
               cmd.issue = 1'b1;
               if (cmd.last) begin
                  col_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
      end
   end

endmodule

/* hw/rtl/ledscan_dp.sv */
// Datapath of the LED bounce scanner: registers, position update and column shading pipeline.
// Depends on ledscan_pkg for constants, register indexes and the command and status types.
module ledscan_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [ledscan_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                            csr_data,
   input  logic [31:0]                           req_now_ms,
   input  ledscan_pkg::ctrl_cmd_type             cmd,
   output ledscan_pkg::dp_status_type            stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_column,
   output logic [7:0]                            rsp_red,
   output logic [7:0]                            rsp_green,
   output logic [7:0]                            rsp_blue,
   output logic                                  rsp_last_column
);
   import ledscan_pkg::*;

   logic [7:0] red_ff, green_ff, blue_ff, speed_ff, intv_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             down_ff, down_in;
   logic [31:0]      last_ff;

   logic signed [SUM_W-1:0] sum;
   logic                    hit_lo, hit_hi;
   logic [31:0]             elapsed;

   logic [POS_W-1:0] colpos, col_dist, rem_w;
   logic [REM_W-1:0] rem;
   logic [BRI_W-1:0] bri_prod;
   logic             lit;

   logic             s1_valid_ff;
   logic [7:0]       s1_bri_ff;
   logic             s1_lit_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_last_ff;

   logic [8:0]  bri_p1;
   logic [16:0] prod_r, prod_g, prod_b;
   logic        rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= 8'd255;
         green_ff <= 8'd0;
         blue_ff  <= 8'd0;
         speed_ff <= 8'd10;
         intv_ff  <= 8'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RED:      red_ff   <= csr_data;
            CSR_GREEN:    green_ff <= csr_data;
            CSR_BLUE:     blue_ff  <= csr_data;
            CSR_SPEED:    speed_ff <= csr_data;
            CSR_INTERVAL: intv_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign elapsed    = req_now_ms - last_ff;
   assign stat.early = (elapsed < {24'd0, intv_ff});
   assign stat.adv   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (down_ff) begin
         sum = $signed(SUM_W'(pos_ff)) - $signed(SUM_W'(speed_ff));
      end else begin
         sum = $signed(SUM_W'(pos_ff)) + $signed(SUM_W'(speed_ff));
      end
      hit_lo  = (sum <= $signed(SUM_W'(0)));
      hit_hi  = (sum >= $signed(SUM_W'(POS_END)));
      down_in = (hit_lo || hit_hi) ? !down_ff : down_ff;
      if (hit_lo) begin
         pos_in = '0;
      end else if (hit_hi) begin
         pos_in = POS_W'(POS_END);
      end else begin
         pos_in = POS_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         down_ff <= 1'b0;
         last_ff <= '0;
      end else if (cmd.frame) begin
         pos_ff  <= pos_in;
         down_ff <= down_in;
         last_ff <= req_now_ms;
      end
   end

   always_comb begin
      colpos   = POS_W'(cmd.col) << POS_FRAC_BITS;
      col_dist = (pos_ff >= colpos) ? (pos_ff - colpos) : (colpos - pos_ff);
      lit      = (col_dist < POS_W'(POS_ONE));
      rem_w    = POS_W'(POS_ONE) - col_dist;
      rem      = lit ? rem_w[REM_W-1:0] : '0;
      bri_prod = (BRI_W'(rem) << 8) - BRI_W'(rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (stat.adv) begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.adv) begin
         s1_bri_ff  <= 8'(bri_prod >> POS_FRAC_BITS);
         s1_lit_ff  <= lit;
         s1_col_ff  <= cmd.col;
         s1_last_ff <= cmd.last;
      end
   end

   assign bri_p1 = {1'b0, s1_bri_ff} + 9'd1;
   assign prod_r = red_ff * bri_p1;
   assign prod_g = green_ff * bri_p1;
   assign prod_b = blue_ff * bri_p1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.adv) begin
         rsp_column      <= 3'(s1_col_ff);
         rsp_red         <= s1_lit_ff ? prod_r[15:8] : 8'd0;
         rsp_green       <= s1_lit_ff ? prod_g[15:8] : 8'd0;
         rsp_blue        <= s1_lit_ff ? prod_b[15:8] : 8'd0;
         rsp_last_column <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/led_scanner_bounce_effect.sv */
// A bounce scanner over six columns: each accepted timestamp that falls at least
// frame_interval milliseconds after the last frame moves the lit spot by speed/256 of a
// column, reversing at either end, and yields one beat per column, column 0 first, with
// last_column set on the final one. A timestamp that comes too early is accepted but yields
// nothing. A frame holds the input while the controller issues one column a cycle, unless
// the result channel stalls, into a two-stage shading pipeline; each column's result passes
// through the stage-one registers and then the response registers, and a stalled result
// channel holds the scan in place. Configuration writes are always ready.
module led_scanner_bounce_effect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ledscan_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                        csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_column,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   output logic                              rsp_last_column
);
   import ledscan_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   assign csr_ready = 1'b1;

   ledscan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ledscan_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_now_ms      (req_now_ms),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column      (rsp_column),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_column (rsp_last_column)
   );

`include "led_scanner_bounce_effect_assert.svh"

   `LSBE_ASSERT_NOW(a_issue_needs_room, cmd.issue, stat.adv)
   `LSBE_ASSERT_NEXT(a_scan_ends, cmd.issue && cmd.last, !cmd.issue && !req_stall)
   `LSBE_ASSERT_NOW(a_last_is_final, rsp_valid && rsp_last_column,
                    rsp_column == 3'(COLUMNS - 1))

endmodule

/* tb/led_scanner_bounce_effect_tb.sv */
// Self-checking testbench for the LED bounce scanner: directed frame timing, bounce and
// register cases, then randomized timestamps checked against an in-bench scan predictor.
// Depends on ledscan_pkg and the led_scanner_bounce_effect top level only.
`timescale 1ns / 100ps

module led_scanner_bounce_effect_tb;
   import ledscan_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 14;
   localparam int STEADY_ITEMS    = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_MAX = {CSR_IDX_W{1'b1}};

   typedef struct packed {
      logic [2:0] column;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } column_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_data = 8'd0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [31:0]          req_now_ms = 32'd0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_column;
   logic [7:0]           rsp_red;
   logic [7:0]           rsp_green;
   logic [7:0]           rsp_blue;
   logic                 rsp_last_column;

   logic [7:0]         cfg_red = 8'd255;
   logic [7:0]         cfg_green = 8'd0;
   logic [7:0]         cfg_blue = 8'd0;
   logic [7:0]         cfg_speed = 8'd10;
   logic [7:0]         cfg_interval = 8'd16;
   logic [POS_W-1:0]   scan_pos = '0;
   logic               scan_down = 1'b0;
   logic [31:0]        last_frame_ms = 32'd0;

   column_beat_type expected_beats[$];
   bit calm = 1'b0;
   int mismatches = 0;
   int beats_checked = 0;
   int frames_made = 0;
   int stamps_sent = 0;
   int writes_done = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   led_scanner_bounce_effect i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_column     (rsp_column),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_column(rsp_last_column)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] dim(input logic [7:0] level, input int bri);
      return 8'((int'(level) * (bri + 1)) >> 8);
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] index,
                                     input logic [7:0] value);
      case (index)
         CSR_RED:      cfg_red = value;
         CSR_GREEN:    cfg_green = value;
         CSR_BLUE:     cfg_blue = value;
         CSR_SPEED:    cfg_speed = value;
         CSR_INTERVAL: cfg_interval = value;
         default: ;
      endcase
   endfunction

   function automatic void predict_frame(input logic [31:0] stamp);
      logic [31:0]     elapsed;
      int              pos;
      int              offset;
      int              bri;
      column_beat_type beat;
      elapsed = stamp - last_frame_ms;
      if (elapsed < {24'd0, cfg_interval}) return;
      last_frame_ms = stamp;
      pos = int'(scan_pos);
      if (scan_down) pos = pos - int'(cfg_speed);
      else pos = pos + int'(cfg_speed);
      if (pos <= 0 || pos >= POS_END) begin
         scan_down = !scan_down;
         pos = (pos <= 0) ? 0 : POS_END;
      end
      scan_pos = POS_W'(pos);
      frames_made++;
      for (int col = 0; col < COLUMNS; col++) begin
         offset = pos - col * POS_ONE;
         if (offset < 0) offset = -offset;
         beat.column = 3'(col);
         beat.last = (col == COLUMNS - 1);
         if (offset < POS_ONE) begin
            bri = (255 * (POS_ONE - offset)) >> POS_FRAC_BITS;
            beat.red = dim(cfg_red, bri);
            beat.green = dim(cfg_green, bri);
            beat.blue = dim(cfg_blue, bri);
         end else begin
            beat.red = 8'd0;
            beat.green = 8'd0;
            beat.blue = 8'd0;
         end
         expected_beats.push_back(beat);
      end
   endfunction

   function automatic logic [7:0] random_speed();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 8'($urandom_range(96, 255));
      if (pick < 85) return 8'($urandom_range(0, 8));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] random_interval();
      if ($urandom_range(0, 99) < 15) return 8'd255;
      return 8'($urandom_range(0, 40));
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_beat
      column_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t ns: unexpected beat, expected none, actual column %0d", $time,
                     rsp_column);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            check_field("column", want.column, rsp_column);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("last_column", want.last, rsp_last_column);
            beats_checked++;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0 && !calm && $urandom_range(0, 99) < 12)
         stall_left = $urandom_range(1, 13);
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no beat for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_stamp(input logic [31:0] stamp);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 25) ? $urandom_range(1, 13) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_now_ms <= stamp;
      do @(posedge clock); while (req_stall);
      stamps_sent++;
      predict_frame(stamp);
   endtask

   task automatic drain_frames();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, value);
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_scan(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic [7:0] speed,
                            input logic [7:0] interval);
      drain_frames();
      write_reg(CSR_RED, red);
      write_reg(CSR_GREEN, green);
      write_reg(CSR_BLUE, blue);
      write_reg(CSR_SPEED, speed);
      write_reg(CSR_INTERVAL, interval);
   endtask

   task automatic send_random_stamp();
      logic [31:0] stamp;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         stamp = last_frame_ms + cfg_interval + $urandom_range(0, 24);
      else if (pick < 88)
         stamp = last_frame_ms + ((cfg_interval == 0) ? 0 : $urandom_range(0, cfg_interval - 1));
      else
         stamp = $urandom();
      send_stamp(stamp);
   endtask

   task automatic test_default_timing();
      send_stamp(32'd0);
      send_stamp(32'd15);
      send_stamp(32'd16);
      send_stamp(32'd31);
      send_stamp(32'd32);
      send_stamp(32'hFFFF_FFFF);
   endtask

   task automatic test_zero_interval_bounce();
      load_scan(8'hFF, 8'h80, 8'h01, 8'hFF, 8'h00);
      repeat (7) send_stamp(last_frame_ms);
   endtask

   task automatic test_zero_speed();
      int guard;
      guard = 0;
      while (scan_pos != 0 && scan_pos != POS_END && guard < 8) begin
         send_stamp(last_frame_ms);
         guard++;
      end
      load_scan(8'hC8, 8'h28, 8'h5A, 8'h00, 8'h00);
      repeat (3) send_stamp(last_frame_ms);
   endtask

   task automatic test_time_wrap();
      load_scan(8'h7F, 8'hFF, 8'h33, 8'h40, 8'hFF);
      send_stamp(32'hFFFF_FF80);
      send_stamp(32'h0000_007E);
      send_stamp(32'h0000_007F);
   endtask

   task automatic test_colour_extremes();
      load_scan(8'h00, 8'hFF, 8'hAA, 8'h90, 8'h05);
      send_stamp(last_frame_ms + 32'd5);
      load_scan(8'hFF, 8'h55, 8'h00, 8'h90, 8'h05);
      send_stamp(last_frame_ms + 32'd9);
   endtask

   task automatic test_unknown_index();
      drain_frames();
      for (int idx = CSR_INTERVAL + 1; idx <= CSR_INDEX_MAX; idx++)
         write_reg(CSR_IDX_W'(idx), (idx % 2 == 0) ? 8'h00 : 8'hFF);
      send_stamp(last_frame_ms + cfg_interval);
   endtask

   task automatic test_random_scan();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            load_scan(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
         else if (phase == 1)
            load_scan(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00);
         else
            load_scan(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), random_speed(), random_interval());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 4) drain_frames();
            send_random_stamp();
         end
      end
   endtask

   task automatic test_steady_stream();
      calm = 1'b1;
      load_scan(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), random_speed(), random_interval());
      repeat (STEADY_ITEMS) send_random_stamp();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_zero_interval_bounce();
      test_zero_speed();
      test_time_wrap();
      test_colour_extremes();
      test_unknown_index();
      test_random_scan();
      test_steady_stream();
      drain_frames();
      repeat (20) @(posedge clock);
      $display("Checked %0d column beats from %0d frames over %0d timestamps, %0d writes.",
               beats_checked, frames_made, stamps_sent, writes_done);
      $display("Covered early frames, zero interval and speed, time wrap, unused indexes.");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ledscan_pkg.sv
hw/rtl/ledscan_ctrl.sv
hw/rtl/ledscan_dp.sv
hw/rtl/led_scanner_bounce_effect.sv
tb/led_scanner_bounce_effect_tb.sv
